[hw/rtl/sfs_pkg.sv]
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types, codes and the control store of the screen fade sequencer.
// ----------------------------------------------------------------------------
package sfs_pkg;

    // brightness and lengths
    localparam int unsigned LEVEL_W   = 5;
    localparam int unsigned SPAN_W    = 16;
    localparam int unsigned TIMER_W   = 17;
    localparam int unsigned REM_W     = TIMER_W + 1;
    localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(16);

    // commands
    localparam logic [1:0] CMD_TICK      = 2'd0;
    localparam logic [1:0] CMD_FADE_OUT  = 2'd1;
    localparam logic [1:0] CMD_FADE_IN   = 2'd2;
    localparam logic [1:0] CMD_FLASH     = 2'd3;

    // transition modes
    localparam logic [1:0] MODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_FADE_OUT = 2'd1;
    localparam logic [1:0] MODE_FLASH    = 2'd2;
    localparam logic [1:0] MODE_FADE_IN  = 2'd3;

    // blend modes
    localparam logic [1:0] BLEND_OFF     = 2'd0;
    localparam logic [1:0] BLEND_WHITE   = 2'd1;
    localparam logic [1:0] BLEND_BLACK   = 2'd2;

    // datapath operations
    typedef logic [2:0] op_t;
    localparam op_t OP_NOP      = 3'd0;
    localparam op_t OP_ACCEPT   = 3'd1;
    localparam op_t OP_START    = 3'd2;
    localparam op_t OP_INC      = 3'd3;
    localparam op_t OP_DIV_LOAD = 3'd4;
    localparam op_t OP_DIV_STEP = 3'd5;
    localparam op_t OP_UPDATE   = 3'd6;
    localparam op_t OP_EMIT     = 3'd7;

    // jump conditions
    typedef logic [2:0] cond_t;
    localparam cond_t COND_NEVER     = 3'd0;
    localparam cond_t COND_ALWAYS    = 3'd1;
    localparam cond_t COND_NO_INPUT  = 3'd2;
    localparam cond_t COND_CMD_TICK  = 3'd3;
    localparam cond_t COND_MODE_IDLE = 3'd4;
    localparam cond_t COND_OUT_BUSY  = 3'd5;

    // program addresses
    typedef logic [3:0] upc_t;
    localparam upc_t UPC_WAIT     = 4'd0;
    localparam upc_t UPC_DECODE   = 4'd1;
    localparam upc_t UPC_START    = 4'd2;
    localparam upc_t UPC_TICK     = 4'd3;
    localparam upc_t UPC_INC      = 4'd4;
    localparam upc_t UPC_DIV_LOAD = 4'd5;
    localparam upc_t UPC_DIV_0    = 4'd6;
    localparam upc_t UPC_DIV_1    = 4'd7;
    localparam upc_t UPC_DIV_2    = 4'd8;
    localparam upc_t UPC_DIV_3    = 4'd9;
    localparam upc_t UPC_DIV_4    = 4'd10;
    localparam upc_t UPC_UPDATE   = 4'd11;
    localparam upc_t UPC_OUT_WAIT = 4'd12;
    localparam upc_t UPC_EMIT     = 4'd13;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        upc_t  target;
    } ctrl_word_t;

    typedef struct packed {
        logic in_valid;
        logic cmd_tick;
        logic mode_idle;
        logic out_busy;
    } status_t;

    // control store: one word per program step
    function automatic ctrl_word_t rom_word(input upc_t addr);
        ctrl_word_t w;
        unique case (addr)
            UPC_WAIT:     w = '{op: OP_ACCEPT,   cond: COND_NO_INPUT,  target: UPC_WAIT};
            UPC_DECODE:   w = '{op: OP_NOP,      cond: COND_CMD_TICK,  target: UPC_TICK};
            UPC_START:    w = '{op: OP_START,    cond: COND_ALWAYS,    target: UPC_OUT_WAIT};
            UPC_TICK:     w = '{op: OP_NOP,      cond: COND_MODE_IDLE, target: UPC_OUT_WAIT};
            UPC_INC:      w = '{op: OP_INC,      cond: COND_NEVER,     target: UPC_WAIT};
            UPC_DIV_LOAD: w = '{op: OP_DIV_LOAD, cond: COND_NEVER,     target: UPC_WAIT};
            UPC_DIV_0:    w = '{op: OP_DIV_STEP, cond: COND_NEVER,     target: UPC_WAIT};
            UPC_DIV_1:    w = '{op: OP_DIV_STEP, cond: COND_NEVER,     target: UPC_WAIT};
            UPC_DIV_2:    w = '{op: OP_DIV_STEP, cond: COND_NEVER,     target: UPC_WAIT};
            UPC_DIV_3:    w = '{op: OP_DIV_STEP, cond: COND_NEVER,     target: UPC_WAIT};
            UPC_DIV_4:    w = '{op: OP_DIV_STEP, cond: COND_NEVER,     target: UPC_WAIT};
            UPC_UPDATE:   w = '{op: OP_UPDATE,   cond: COND_NEVER,     target: UPC_WAIT};
            UPC_OUT_WAIT: w = '{op: OP_NOP,      cond: COND_OUT_BUSY,  target: UPC_OUT_WAIT};
            UPC_EMIT:     w = '{op: OP_EMIT,     cond: COND_ALWAYS,    target: UPC_WAIT};
            default:      w = '{op: OP_NOP,      cond: COND_ALWAYS,    target: UPC_WAIT};
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/sfs_sequencer.sv]
// ----------------------------------------------------------------------------
// sfs_sequencer
// Step counter, control store read and conditional jump logic.
// ----------------------------------------------------------------------------
module sfs_sequencer import sfs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  status_t    status,
    output ctrl_word_t ctrl
);

    upc_t upc_reg;
    upc_t upc_next;
    logic jump;

    // current control word
    assign ctrl = rom_word(upc_reg);

    // jump condition select
    always_comb begin
        unique case (ctrl.cond)
            COND_NEVER:     jump = 1'b0;
            COND_ALWAYS:    jump = 1'b1;
            COND_NO_INPUT:  jump = !status.in_valid;
            COND_CMD_TICK:  jump = status.cmd_tick;
            COND_MODE_IDLE: jump = status.mode_idle;
            COND_OUT_BUSY:  jump = status.out_busy;
            default:        jump = 1'b1;
        endcase
        upc_next = jump ? ctrl.target : upc_reg + upc_t'(1);
    end

    // step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= UPC_WAIT;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

[hw/rtl/sfs_datapath.sv]
// ----------------------------------------------------------------------------
// sfs_datapath
// Transition state, frame timer, shift-subtract divider and result register,
// each driven by the operation field of the current control word.
// ----------------------------------------------------------------------------
module sfs_datapath import sfs_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  ctrl_word_t         ctrl,
    output status_t            status,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [SPAN_W-1:0]  s_span_frames,
    input  logic [SPAN_W-1:0]  s_fade_span_frames,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_active,
    output logic [1:0]         m_blend_mode,
    output logic [LEVEL_W-1:0] m_level
);

    // latched input word
    logic [1:0]         cmd_reg;
    logic [SPAN_W-1:0]  span_reg;
    logic [SPAN_W-1:0]  fade_span_reg;

    // transition state
    logic [1:0]         mode_reg,   mode_next;
    logic [TIMER_W-1:0] timer_reg,  timer_next;
    logic [TIMER_W-1:0] total_reg,  total_next;
    logic [SPAN_W-1:0]  hold_reg,   hold_next;
    logic [SPAN_W-1:0]  fade_reg,   fade_next;
    logic [LEVEL_W-1:0] level_reg,  level_next;
    logic [1:0]         blend_reg,  blend_next;

    // divider
    logic [REM_W-1:0]   rem_reg,    rem_next;
    logic [TIMER_W-1:0] den_reg,    den_next;
    logic [LEVEL_W-1:0] quo_reg,    quo_next;

    // result register
    logic               m_valid_reg;
    logic               m_active_reg;
    logic [1:0]         m_blend_reg;
    logic [LEVEL_W-1:0] m_level_reg;

    logic [SPAN_W-1:0]  span_min1;
    logic [SPAN_W-1:0]  fade_min1;
    logic               div_ge;
    logic [REM_W-1:0]   rem_diff;
    logic               done;
    logic [LEVEL_W-1:0] falling;
    logic               accept;

    assign s_ready = (ctrl.op == OP_ACCEPT);
    assign accept  = s_valid && s_ready;

    // status back to the sequencer
    assign status.in_valid  = s_valid;
    assign status.cmd_tick  = (cmd_reg == CMD_TICK);
    assign status.mode_idle = (mode_reg == MODE_IDLE);
    assign status.out_busy  = m_valid_reg && !m_ready;

    // zero lengths count as one frame
    assign span_min1 = (span_reg == '0) ? SPAN_W'(1) : span_reg;
    assign fade_min1 = (fade_span_reg == '0) ? SPAN_W'(1) : fade_span_reg;

    // one restoring division step
    assign div_ge   = (rem_reg >= {1'b0, den_reg});
    assign rem_diff = div_ge ? rem_reg - {1'b0, den_reg} : rem_reg;

    assign done    = (timer_reg >= total_reg);
    assign falling = (quo_reg >= FULL_LEVEL) ? '0 : FULL_LEVEL - quo_reg;

    // next state by operation
    always_comb begin
        mode_next  = mode_reg;
        timer_next = timer_reg;
        total_next = total_reg;
        hold_next  = hold_reg;
        fade_next  = fade_reg;
        level_next = level_reg;
        blend_next = blend_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        quo_next   = quo_reg;
        unique case (ctrl.op)
            OP_START: begin
                timer_next = '0;
                unique case (cmd_reg)
                    CMD_FADE_OUT: begin
                        mode_next  = MODE_FADE_OUT;
                        total_next = {1'b0, span_min1};
                        blend_next = BLEND_WHITE;
                    end
                    CMD_FADE_IN: begin
                        mode_next  = MODE_FADE_IN;
                        total_next = {1'b0, span_min1};
                        blend_next = BLEND_BLACK;
                        level_next = FULL_LEVEL;
                    end
                    CMD_FLASH: begin
                        mode_next  = MODE_FLASH;
                        hold_next  = span_min1;
                        fade_next  = fade_min1;
                        total_next = {1'b0, span_min1} + {1'b0, fade_min1};
                        blend_next = BLEND_WHITE;
                    end
                    default: begin
                        mode_next = mode_reg;
                    end
                endcase
            end
            OP_INC: begin
                timer_next = timer_reg + TIMER_W'(1);
            end
            OP_DIV_LOAD: begin
                quo_next = '0;
                if (mode_reg == MODE_FLASH) begin
                    den_next = {1'b0, fade_reg};
                    if (timer_reg > {1'b0, hold_reg}) begin
                        rem_next = {1'b0, timer_reg - {1'b0, hold_reg}};
                    end else begin
                        rem_next = '0;
                    end
                end else begin
                    den_next = total_reg;
                    rem_next = {1'b0, timer_reg};
                end
            end
            OP_DIV_STEP: begin
                rem_next = {rem_diff[REM_W-2:0], 1'b0};
                quo_next = {quo_reg[LEVEL_W-2:0], div_ge};
            end
            OP_UPDATE: begin
                unique case (mode_reg)
                    MODE_FADE_OUT: begin
                        level_next = (quo_reg > FULL_LEVEL) ? FULL_LEVEL : quo_reg;
                        if (done) begin
                            mode_next = MODE_IDLE;
                        end
                    end
                    MODE_FLASH, MODE_FADE_IN: begin
                        if (mode_reg == MODE_FLASH && timer_reg <= {1'b0, hold_reg}) begin
                            level_next = FULL_LEVEL;
                        end else begin
                            level_next = falling;
                        end
                        if (done) begin
                            level_next = '0;
                            blend_next = BLEND_OFF;
                            mode_next  = MODE_IDLE;
                        end
                    end
                    default: begin
                        mode_next = mode_reg;
                    end
                endcase
            end
            default: begin
                mode_next = mode_reg;
            end
        endcase
    end

    // transition state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            timer_reg <= '0;
            total_reg <= '0;
            hold_reg  <= '0;
            fade_reg  <= '0;
            level_reg <= '0;
            blend_reg <= BLEND_OFF;
        end else begin
            mode_reg  <= mode_next;
            timer_reg <= timer_next;
            total_reg <= total_next;
            hold_reg  <= hold_next;
            fade_reg  <= fade_next;
            level_reg <= level_next;
            blend_reg <= blend_next;
        end
    end

    // input word and divider working registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg       <= s_command;
            span_reg      <= s_span_frames;
            fade_span_reg <= s_fade_span_frames;
        end
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    // result register, loaded only when empty or being taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.op == OP_EMIT) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.op == OP_EMIT) begin
            m_active_reg <= (mode_reg != MODE_IDLE);
            m_blend_reg  <= blend_reg;
            m_level_reg  <= level_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_active     = m_active_reg;
    assign m_blend_mode = m_blend_reg;
    assign m_level      = m_level_reg;

endmodule

[hw/rtl/screen_fade_sequencer_top.sv]
// ----------------------------------------------------------------------------
// screen_fade_sequencer_top
// Frame-driven screen brightness transition sequencer, run by a short
// microprogram over a small datapath with a shift-subtract divider.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | word
//  ---------+--------------------+----------------------------------------------
//  input    | s_valid / s_ready  | s_command, s_span_frames, s_fade_span_frames
//  result   | m_valid / m_ready  | m_active, m_blend_mode, m_level
//
//  a running tick steps from acceptance through decode, tick, increment,
//  divider load, five divider steps, update and output wait to the result
//  load; a start command or an idle tick skips increment, divider and update
//  the next word is taken in the cycle after the result is loaded, while
//  that result may still be waiting in the output register
//  a stalled result holds the sequencer in its output wait step
//  aresetn is synchronous, active low, and clears all transition state
//
module screen_fade_sequencer_top import sfs_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [SPAN_W-1:0]  s_span_frames,
    input  logic [SPAN_W-1:0]  s_fade_span_frames,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_active,
    output logic [1:0]         m_blend_mode,
    output logic [LEVEL_W-1:0] m_level
);

    ctrl_word_t ctrl;
    status_t    status;

    // microprogram control
    sfs_sequencer u_sequencer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    // state, divider and result register
    sfs_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .ctrl               (ctrl),
        .status             (status),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_command          (s_command),
        .s_span_frames      (s_span_frames),
        .s_fade_span_frames (s_fade_span_frames),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_active           (m_active),
        .m_blend_mode       (m_blend_mode),
        .m_level            (m_level)
    );

endmodule

[bench/screen_fade_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// screen_fade_checker
// Passive monitor for the screen fade sequencer: tracks every accepted input
// word, predicts the result word it causes and compares each accepted result
// field by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module screen_fade_checker import sfs_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [SPAN_W-1:0]  s_span_frames,
    input  logic [SPAN_W-1:0]  s_fade_span_frames,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_active,
    input  logic [1:0]         m_blend_mode,
    input  logic [LEVEL_W-1:0] m_level,
    output int unsigned        mismatch_count,
    output int unsigned        words_outstanding
);

    typedef struct packed {
        logic               active;
        logic [1:0]         blend_mode;
        logic [LEVEL_W-1:0] level;
    } fade_word_t;

    // shadow copy of the sequencer state
    logic [1:0]         fade_mode;
    logic [TIMER_W-1:0] frame_count;
    logic [TIMER_W-1:0] run_length;
    logic [SPAN_W-1:0]  hold_frames;
    logic [SPAN_W-1:0]  tail_frames;
    logic [LEVEL_W-1:0] level_now;
    logic [1:0]         blend_now;

    fade_word_t expected_words[$];

    // a zero length counts as one frame
    function automatic logic [SPAN_W-1:0] span_or_one(input logic [SPAN_W-1:0] span);
        return (span == '0) ? SPAN_W'(1) : span;
    endfunction

    // full level less num/den of it, clamped at zero
    function automatic logic [LEVEL_W-1:0] falling_level(input int unsigned num,
                                                         input int unsigned den);
        int unsigned q;
        q = num * FULL_LEVEL / den;
        return (q >= FULL_LEVEL) ? '0 : FULL_LEVEL - LEVEL_W'(q);
    endfunction

    // one frame of the running transition
    task automatic advance_frame();
        int unsigned q;
        logic        finished;
        if (fade_mode != MODE_IDLE) begin
            frame_count = frame_count + TIMER_W'(1);
            finished = (frame_count >= run_length);
            case (fade_mode)
                MODE_FADE_OUT: begin
                    q = 32'(frame_count) * FULL_LEVEL / 32'(run_length);
                    level_now = (q > FULL_LEVEL) ? FULL_LEVEL : LEVEL_W'(q);
                    if (finished) begin
                        fade_mode = MODE_IDLE;
                    end
                end
                MODE_FLASH: begin
                    if (frame_count <= TIMER_W'(hold_frames)) begin
                        level_now = FULL_LEVEL;
                    end else begin
                        level_now = falling_level(32'(frame_count - TIMER_W'(hold_frames)),
                                                  32'(tail_frames));
                    end
                    if (finished) begin
                        level_now = '0;
                        blend_now = BLEND_OFF;
                        fade_mode = MODE_IDLE;
                    end
                end
                default: begin
                    level_now = falling_level(32'(frame_count), 32'(run_length));
                    if (finished) begin
                        level_now = '0;
                        blend_now = BLEND_OFF;
                        fade_mode = MODE_IDLE;
                    end
                end
            endcase
        end
    endtask

    // apply one input word and give the result word it causes
    task automatic apply_word(input logic [1:0] cmd, input logic [SPAN_W-1:0] span,
                              input logic [SPAN_W-1:0] fade_span, output fade_word_t res);
        case (cmd)
            CMD_FADE_OUT: begin
                fade_mode   = MODE_FADE_OUT;
                frame_count = '0;
                run_length  = TIMER_W'(span_or_one(span));
                blend_now   = BLEND_WHITE;
            end
            CMD_FADE_IN: begin
                fade_mode   = MODE_FADE_IN;
                frame_count = '0;
                run_length  = TIMER_W'(span_or_one(span));
                blend_now   = BLEND_BLACK;
                level_now   = FULL_LEVEL;
            end
            CMD_FLASH: begin
                fade_mode   = MODE_FLASH;
                frame_count = '0;
                hold_frames = span_or_one(span);
                tail_frames = span_or_one(fade_span);
                run_length  = TIMER_W'(hold_frames) + TIMER_W'(tail_frames);
                blend_now   = BLEND_WHITE;
            end
            default: begin
                advance_frame();
            end
        endcase
        res.active     = (fade_mode != MODE_IDLE);
        res.blend_mode = blend_now;
        res.level      = level_now;
    endtask

    // predict on input words, compare on result words
    always @(posedge aclk) begin : word_tracker
        fade_word_t  predicted;
        int unsigned errs;
        errs = 0;
        if (!aresetn) begin
            fade_mode   = MODE_IDLE;
            frame_count = '0;
            run_length  = '0;
            hold_frames = '0;
            tail_frames = '0;
            level_now   = '0;
            blend_now   = BLEND_OFF;
            expected_words.delete();
        end else begin
            if (s_valid && s_ready) begin
                apply_word(s_command, s_span_frames, s_fade_span_frames, predicted);
                expected_words.push_back(predicted);
            end
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word with nothing predicted: active %0d blend_mode %0d level %0d",
                           m_active, m_blend_mode, m_level);
                    errs++;
                end else begin
                    predicted = expected_words.pop_front();
                    if (m_active !== predicted.active) begin
                        $error("active: expected %0d, actual %0d", predicted.active, m_active);
                        errs++;
                    end
                    if (m_blend_mode !== predicted.blend_mode) begin
                        $error("blend_mode: expected %0d, actual %0d",
                               predicted.blend_mode, m_blend_mode);
                        errs++;
                    end
                    if (m_level !== predicted.level) begin
                        $error("level: expected %0d, actual %0d", predicted.level, m_level);
                        errs++;
                    end
                end
            end
        end
        mismatch_count    <= mismatch_count + errs;
        words_outstanding <= expected_words.size();
    end

endmodule

[bench/tb_screen_fade_sequencer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_screen_fade_sequencer_top
// Regression bench for the screen fade sequencer: directed transitions
// followed by random start/tick sequences under varying idle and back-pressure,
// with a side checker predicting and comparing every result word.
// ----------------------------------------------------------------------------
module tb_screen_fade_sequencer_top import sfs_pkg::*; ();

    localparam int unsigned QUIET_LIMIT     = 5000;
    localparam int unsigned DRAIN_CYCLES    = 20;
    localparam int unsigned WORDS_PER_PHASE = 250;

    logic               aclk               = 1'b0;
    logic               aresetn            = 1'b0;
    logic               s_valid            = 1'b0;
    logic [1:0]         s_command          = CMD_TICK;
    logic [SPAN_W-1:0]  s_span_frames      = '0;
    logic [SPAN_W-1:0]  s_fade_span_frames = '0;
    logic               m_ready            = 1'b0;
    logic               s_ready;
    logic               m_valid;
    logic               m_active;
    logic [1:0]         m_blend_mode;
    logic [LEVEL_W-1:0] m_level;

    int unsigned send_gap_pct   = 0;
    int unsigned take_stall_pct = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned mismatch_count;
    int unsigned words_outstanding;

    always #1 aclk = ~aclk;

    screen_fade_sequencer_top DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_command          (s_command),
        .s_span_frames      (s_span_frames),
        .s_fade_span_frames (s_fade_span_frames),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_active           (m_active),
        .m_blend_mode       (m_blend_mode),
        .m_level            (m_level)
    );

    screen_fade_checker u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_command          (s_command),
        .s_span_frames      (s_span_frames),
        .s_fade_span_frames (s_fade_span_frames),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_active           (m_active),
        .m_blend_mode       (m_blend_mode),
        .m_level            (m_level),
        .mismatch_count     (mismatch_count),
        .words_outstanding  (words_outstanding)
    );

    // result side back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= take_stall_pct);
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("screen_fade_sequencer_top regression: fail");
            $finish;
        end
    end

    // present one word, with a random gap first, and wait for its acceptance
    task automatic send_word(input logic [1:0] cmd, input logic [SPAN_W-1:0] span,
                             input logic [SPAN_W-1:0] fade_span);
        if ($urandom_range(0, 99) < send_gap_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_gap_pct);
        end
        s_valid            <= 1'b1;
        s_command          <= cmd;
        s_span_frames      <= span;
        s_fade_span_frames <= fade_span;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // tick with junk in the unused length fields
    task automatic send_tick();
        send_word(CMD_TICK, 16'($urandom), 16'($urandom));
    endtask

    // mostly short lengths, now and then zero or anything at all
    function automatic logic [SPAN_W-1:0] pick_span();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            return 16'($urandom);
        end else if (r == 1) begin
            return '0;
        end
        return SPAN_W'($urandom_range(1, 12));
    endfunction

    // start commands followed by runs of ticks, mostly to the end, plus stray words
    task automatic run_random_words(input int unsigned count);
        int unsigned       sent;
        int unsigned       frames;
        int unsigned       ticks;
        logic [1:0]        cmd;
        logic [SPAN_W-1:0] span;
        logic [SPAN_W-1:0] fade_span;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) == 0) begin
                send_word(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
                sent++;
            end else begin
                case ($urandom_range(0, 2))
                    0:       cmd = CMD_FADE_OUT;
                    1:       cmd = CMD_FADE_IN;
                    default: cmd = CMD_FLASH;
                endcase
                span      = pick_span();
                fade_span = pick_span();
                frames = (span == '0) ? 1 : span;
                if (cmd == CMD_FLASH) begin
                    frames += (fade_span == '0) ? 1 : fade_span;
                end
                if (frames > 40) begin
                    ticks = $urandom_range(0, 6);
                end else if ($urandom_range(0, 3) == 0) begin
                    ticks = $urandom_range(0, frames);
                end else begin
                    ticks = frames + $urandom_range(0, 3);
                end
                send_word(cmd, span, fade_span);
                repeat (ticks) send_tick();
                sent += 1 + ticks;
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // idle tick, zero and full lengths, every ending, restart mid-fade
        send_word(CMD_TICK, '1, '1);
        send_word(CMD_FADE_IN, '0, '1);
        send_tick();
        send_word(CMD_FADE_OUT, 16'd2, '0);
        repeat (3) send_tick();
        send_word(CMD_FLASH, '0, '0);
        repeat (2) send_tick();
        send_word(CMD_FADE_OUT, '1, '0);
        send_tick();
        send_word(CMD_FADE_IN, 16'd3, '1);
        repeat (3) send_tick();
        send_word(CMD_FLASH, '1, '1);
        send_tick();
        send_word(CMD_FLASH, 16'd2, 16'd3);
        repeat (6) send_tick();

        // random phases under different idling
        run_random_words(WORDS_PER_PHASE);
        send_gap_pct = 87;
        run_random_words(WORDS_PER_PHASE);
        send_gap_pct   = 0;
        take_stall_pct = 87;
        run_random_words(WORDS_PER_PHASE);
        send_gap_pct   = 24;
        take_stall_pct = 24;
        run_random_words(WORDS_PER_PHASE);
        s_valid <= 1'b0;

        // drain outstanding results, then allow for stray late words
        @(posedge aclk);
        while (words_outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && words_outstanding == 0) begin
            $display("screen_fade_sequencer_top regression: pass");
        end else begin
            $display("screen_fade_sequencer_top regression: fail");
        end
        $finish;
    end

endmodule
